>>> sv/lwtf_pkg.sv
// Shared types and constants for the table waveshaper with tone filter.
// Used by the channel interfaces and every module of the block.
package lwtf_pkg;

   // Table depth default, handed to the top level parameter.
   localparam int TABLE_DEPTH_DEFAULT = 1024;

   // Field widths fixed by the item and register formats.
   localparam int OP_W        = 2;
   localparam int SAMPLE_W    = 16;
   localparam int INDEX_W     = 10;
   localparam int GAIN_W      = 23;
   localparam int COEF_W      = 17;
   localparam int VOL_W       = 17;
   localparam int ENTRY_W     = 11;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 23;
   localparam int STATE_W     = 24;
   localparam int MAG_W       = 32;
   localparam int FRAC_W      = 16;

   // Depth of the queue between front and back end.
   localparam int QUEUE_DEPTH = 2;

   // Unity in Q1.16 and the largest product magnitude (1.0 in Q31).
   localparam logic [COEF_W-1:0] UNITY_Q16 = 17'h10000;
   localparam logic [MAG_W-1:0]  MAG_LIMIT = 32'h8000_0000;

   // Register reset values.
   localparam logic [GAIN_W-1:0]  GAIN_RESET    = 23'd65536;
   localparam logic [COEF_W-1:0]  COEF_RESET    = 17'd65536;
   localparam logic [VOL_W-1:0]   VOL_RESET     = 17'd65536;
   localparam logic [ENTRY_W-1:0] ENTRIES_RESET = 11'd1024;

   // Request operation codes.
   typedef enum logic [OP_W-1:0] {
      OP_PROCESS = 2'd0,
      OP_WR_POS  = 2'd1,
      OP_WR_NEG  = 2'd2
   } op_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DRIVE_GAIN = 2'd0,
      CSR_TONE_COEF  = 2'd1,
      CSR_OUTPUT_VOL = 2'd2,
      CSR_ENTRIES    = 2'd3
   } csr_index_type;

   // One queued request after classification.
   typedef struct packed {
      op_type                      kind;
      logic signed [SAMPLE_W-1:0]  sample;
      logic [INDEX_W-1:0]          index;
      logic                        block_end;
   } queue_item_type;

   // Head of the queue as seen by the back end.
   typedef struct packed {
      logic           valid;
      queue_item_type item;
   } queue_head_type;

endpackage

>>> sv/lwtf_if.sv
// Request and response channel interfaces with valid/ready handshake.
// Depends on lwtf_pkg for the field widths.
interface lwtf_req_if import lwtf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [OP_W-1:0]            operation;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic [INDEX_W-1:0]         table_index;
   logic                       block_end;

   modport source (output valid, operation, sample_in, table_index, block_end,
                   input ready);
   modport sink (input valid, operation, sample_in, table_index, block_end,
                 output ready);
endinterface

interface lwtf_rsp_if import lwtf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;
   logic                       block_end_out;

   modport source (output valid, sample_out, block_end_out, input ready);
   modport sink (input valid, sample_out, block_end_out, output ready);
endinterface

>>> sv/lwtf_front.sv
// Front end: accepts requests, drops those without effect, queues the rest.
// Depends on lwtf_pkg and lwtf_req_if.
module lwtf_front import lwtf_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   lwtf_req_if.sink       req_ch,
   output queue_head_type head,
   input  logic           pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_item_type queue_mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic           accept;
   logic           keep;
   logic           push;
   queue_item_type item;

   // The request is taken whenever the queue has room.
   assign req_ch.ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign accept       = req_ch.valid && req_ch.ready;

   // Classify: samples always go on, table writes only when in range.
   always_comb begin
      unique case (req_ch.operation) inside
         OP_PROCESS:           keep = 1'b1;
         OP_WR_POS, OP_WR_NEG: keep = (32'(req_ch.table_index) < TABLE_DEPTH);
         default:              keep = 1'b0;
      endcase
   end

   assign push = accept && keep;

   always_comb begin
      item.kind      = op_type'(req_ch.operation);
      item.sample    = req_ch.sample_in;
      item.index     = req_ch.table_index;
      item.block_end = req_ch.block_end;
   end

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = queue_mem[rd_ptr_ff];

endmodule

>>> sv/lwtf_back.sv
// Back end: curve tables, lookup with interpolation, tone filter and volume.
// Depends on lwtf_pkg and lwtf_rsp_if; fed by the queue in lwtf_front.
module lwtf_back import lwtf_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  queue_head_type         head,
   output logic                   pop,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   lwtf_rsp_if.source             rsp_ch
);

   localparam int AW     = $clog2(TABLE_DEPTH);
   localparam int MAGF_W = SAMPLE_W + GAIN_W;
   localparam int POS_W  = MAG_W + ENTRY_W;
   localparam int IDX_W  = POS_W - MAG_W + 1;
   localparam int WET_W  = SAMPLE_W + 1;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_MAG    = 7'b0000010,
      ST_POS    = 7'b0000100,
      ST_ADDR   = 7'b0001000,
      ST_INTERP = 7'b0010000,
      ST_FILT   = 7'b0100000,
      ST_SCALE  = 7'b1000000
   } back_state_type;

   back_state_type state_ff, state_in;

   // Configuration registers.
   logic [GAIN_W-1:0]  gain_ff;
   logic [COEF_W-1:0]  coef_ff;
   logic [VOL_W-1:0]   vol_ff;
   logic [ENTRY_W-1:0] entries_ff;

   // Curve tables.
   logic signed [SAMPLE_W-1:0] pos_curve_mem [TABLE_DEPTH];
   logic signed [SAMPLE_W-1:0] neg_curve_mem [TABLE_DEPTH];

   // Datapath registers.
   logic signed [SAMPLE_W-1:0] s_ff, s_in;
   logic                       blk_ff, blk_in;
   logic                       neg_ff, neg_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [FRAC_W-1:0]          frac_ff, frac_in;
   logic signed [SAMPLE_W-1:0] pa_ff, pb_ff, na_ff, nb_ff;
   logic signed [WET_W-1:0]    wet_ff, wet_in;
   logic signed [STATE_W-1:0]  filt_ff, filt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_end_ff, rsp_end_in;

   // Combinational helpers.
   logic [COEF_W-1:0]          coef_eff;
   logic [VOL_W-1:0]           vol_eff;
   logic [ENTRY_W-1:0]         last_idx;
   logic [SAMPLE_W-1:0]        abs_s;
   logic [MAGF_W-1:0]          mag_full;
   logic [IDX_W-1:0]           idx;
   logic                       at_top;
   logic [AW-1:0]              addr_a, addr_b;
   logic                       rd_en;
   logic                       we_pos, we_neg;
   logic [AW-1:0]              wr_addr;
   logic signed [SAMPLE_W-1:0] tab_a, tab_b;
   logic signed [WET_W-1:0]    diff;
   logic signed [33:0]         prod_i, rnd_i;
   logic signed [17:0]         r_i, r_neg;
   logic signed [STATE_W-1:0]  x_f;
   logic signed [STATE_W:0]    delta_f;
   logic signed [42:0]         prod_f, rnd_f;
   logic signed [41:0]         prod_s, rnd_s;
   logic signed [18:0]         y_s;
   logic [SAMPLE_W-1:0]        y_sat;
   logic                       out_free;
   logic                       load_out;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= GAIN_RESET;
         coef_ff    <= COEF_RESET;
         vol_ff     <= VOL_RESET;
         entries_ff <= ENTRIES_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_DRIVE_GAIN: gain_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_TONE_COEF:  coef_ff    <= csr_wdata[COEF_W-1:0];
            CSR_OUTPUT_VOL: vol_ff     <= csr_wdata[VOL_W-1:0];
            CSR_ENTRIES:    entries_ff <= csr_wdata[ENTRY_W-1:0];
            default:        gain_ff    <= gain_ff;
         endcase
      end
   end

   // Clamp coefficient, volume and the last usable table entry.
   always_comb begin
      coef_eff = (coef_ff > UNITY_Q16) ? UNITY_Q16 : coef_ff;
      vol_eff  = (vol_ff > VOL_W'(UNITY_Q16)) ? VOL_W'(UNITY_Q16) : vol_ff;
      if (entries_ff < ENTRY_W'(2)) begin
         last_idx = ENTRY_W'(1);
      end else if (32'(entries_ff) > TABLE_DEPTH) begin
         last_idx = ENTRY_W'(TABLE_DEPTH - 1);
      end else begin
         last_idx = entries_ff - ENTRY_W'(1);
      end
   end

   // Step one: scaled magnitude, saturated to 1.0 in Q31.
   assign abs_s    = s_ff[SAMPLE_W-1] ? (~s_ff + SAMPLE_W'(1)) : s_ff;
   assign mag_full = MAGF_W'(abs_s) * MAGF_W'(gain_ff);
   assign mag_in   = (mag_full > MAGF_W'(MAG_LIMIT)) ? MAG_LIMIT : mag_full[MAG_W-1:0];
   assign neg_in   = s_ff[SAMPLE_W-1] && (gain_ff != '0);

   // Step two: position along the curve.
   assign pos_in = POS_W'(mag_ff) * POS_W'(last_idx);

   // Step three: entry addresses and fraction; at the top only the last entry counts.
   assign idx     = pos_ff[POS_W-1:MAG_W-1];
   assign at_top  = (idx >= IDX_W'(last_idx));
   assign addr_a  = at_top ? AW'(last_idx) : AW'(idx);
   assign addr_b  = at_top ? AW'(last_idx) : AW'(idx + IDX_W'(1));
   assign frac_in = at_top ? '0 : pos_ff[MAG_W-2 -: FRAC_W];
   assign rd_en   = (state_ff == ST_ADDR);

   // Table writes come straight from the queue head.
   assign pop     = (state_ff == ST_IDLE) && head.valid;
   assign we_pos  = pop && (head.item.kind == OP_WR_POS);
   assign we_neg  = pop && (head.item.kind == OP_WR_NEG);
   assign wr_addr = AW'(head.item.index);

   always_ff @(posedge clock) begin
      if (we_pos) begin
         pos_curve_mem[wr_addr] <= head.item.sample;
      end
      if (rd_en) begin
         pa_ff <= pos_curve_mem[addr_a];
         pb_ff <= pos_curve_mem[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (we_neg) begin
         neg_curve_mem[wr_addr] <= head.item.sample;
      end
      if (rd_en) begin
         na_ff <= neg_curve_mem[addr_a];
         nb_ff <= neg_curve_mem[addr_b];
      end
   end

   // Step four: linear interpolation with round half up, then sign restore.
   assign tab_a  = neg_ff ? na_ff : pa_ff;
   assign tab_b  = neg_ff ? nb_ff : pb_ff;
   assign diff   = WET_W'(tab_b) - WET_W'(tab_a);
   assign prod_i = $signed({1'b0, frac_ff}) * diff;
   assign rnd_i  = prod_i + 34'sd32768;
   assign r_i    = 18'(tab_a) + rnd_i[33:16];
   assign r_neg  = -r_i;
   assign wet_in = neg_ff ? r_neg[WET_W-1:0] : r_i[WET_W-1:0];

   // Step five: one-pole lowpass update of the Q2.22 state.
   assign x_f     = {wet_ff, 7'b0};
   assign delta_f = (STATE_W + 1)'(x_f) - (STATE_W + 1)'(filt_ff);
   assign prod_f  = $signed({1'b0, coef_eff}) * delta_f;
   assign rnd_f   = prod_f + 43'sd32768;
   assign filt_in = filt_ff + rnd_f[16 +: STATE_W];

   // Step six: volume with rounding and saturation.
   assign prod_s = filt_ff * $signed({1'b0, vol_eff});
   assign rnd_s  = prod_s + 42'sd4194304;
   assign y_s    = rnd_s[41:23];

   always_comb begin
      if (y_s > 19'sd32767) begin
         y_sat = 16'h7FFF;
      end else if (y_s < -19'sd32768) begin
         y_sat = 16'h8000;
      end else begin
         y_sat = y_s[SAMPLE_W-1:0];
      end
   end

   // Output register lets the next sample start while a result waits.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign load_out = (state_ff == ST_SCALE) && out_free;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_end_in    = rsp_end_ff;
      if (load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = y_sat;
         rsp_end_in    = blk_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Sequencer: at most one multiply per step, one sample at a time.
   always_comb begin
      state_in = state_ff;
      s_in     = s_ff;
      blk_in   = blk_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop && (head.item.kind == OP_PROCESS)) begin
               s_in     = head.item.sample;
               blk_in   = head.item.block_end;
               state_in = ST_MAG;
            end
         end
         ST_MAG:    state_in = ST_POS;
         ST_POS:    state_in = ST_ADDR;
         ST_ADDR:   state_in = ST_INTERP;
         ST_INTERP: state_in = ST_FILT;
         ST_FILT:   state_in = ST_SCALE;
         ST_SCALE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         filt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_FILT) begin
            filt_ff <= filt_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s_ff          <= s_in;
      blk_ff        <= blk_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_end_ff    <= rsp_end_in;
      if (state_ff == ST_MAG) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
      if (state_ff == ST_POS) begin
         pos_ff <= pos_in;
      end
      if (state_ff == ST_ADDR) begin
         frac_ff <= frac_in;
      end
      if (state_ff == ST_INTERP) begin
         wet_ff <= wet_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.sample_out    = rsp_sample_ff;
   assign rsp_ch.block_end_out = rsp_end_ff;

`ifndef SYNTHESIS
   // A new result only appears right after the volume step.
   a_rsp_from_scale: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid_ff) |-> $past(state_ff == ST_SCALE))
      else $error("response raised without a completed sample");

   // The filter state moves only on the filter step.
   a_filt_on_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(filt_ff) |-> $past(state_ff == ST_FILT))
      else $error("filter state changed outside the filter step");

   // Work on a sample starts only from a queued sample request.
   a_mag_from_queue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAG) |->
         $past(state_ff == ST_IDLE && head.valid && head.item.kind == OP_PROCESS))
      else $error("sample processing started without a queued sample");
`endif

endmodule

>>> sv/lut_waveshaper_with_tone_filter_core.sv
// A sample request goes through the queue to the back-end sequencer, which works on one
// sample at a time through six steps (magnitude, position, address, interpolation, filter,
// volume) with at most one multiply per step and waits in the volume step while the output
// register is full; a table write is done by the back end straight from the queue head.
// Reset (synchronous, active high) restores register defaults, clears the filter
// state and the queue; curve tables are not cleared and must be written first.
module lut_waveshaper_with_tone_filter_core import lwtf_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   lwtf_req_if.sink               req_ch,
   lwtf_rsp_if.source             rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   queue_head_type head;
   logic           pop;

   // Front end: request intake and queue.
   lwtf_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .head   (head),
      .pop    (pop)
   );

   // Back end: tables, shaping, filter and output register.
   lwtf_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_ch    (rsp_ch)
   );

endmodule

>>> sim/tb_lut_waveshaper_with_tone_filter_core.sv
`timescale 1ns / 1ps
// Self-checking bench for lut_waveshaper_with_tone_filter_core: loads both curve tables,
// runs a directed table of corner cases, then random traffic checked by a built-in predictor.
// Depends on lwtf_pkg, the lwtf_req_if and lwtf_rsp_if interfaces and the core itself.
module tb_lut_waveshaper_with_tone_filter_core;
   import lwtf_pkg::*;

   localparam int TABLE_SIZE = TABLE_DEPTH_DEFAULT;
   localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_ITEMS = 1700;
   localparam int PHASES = 12;
   localparam int MAX_REPORTS = 40;

   // One expected response.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       block_end;
   } shaped_sample_type;

   // One line of the directed table: either a register write or a request.
   typedef struct packed {
      logic                       is_reg;
      csr_index_type              reg_sel;
      logic [CSR_DATA_W-1:0]      reg_data;
      logic [OP_W-1:0]            op;
      logic signed [SAMPLE_W-1:0] sample;
      logic [INDEX_W-1:0]         index;
      logic                       block_end;
      logic                       known;
      logic signed [SAMPLE_W-1:0] known_out;
   } directed_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   lwtf_req_if req_ch ();
   lwtf_rsp_if rsp_ch ();

   lut_waveshaper_with_tone_filter_core #(.TABLE_DEPTH(TABLE_SIZE)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor copy of the registers, filter state and curve tables.
   logic [GAIN_W-1:0]          gain_m;
   logic [COEF_W-1:0]          tone_m;
   logic [VOL_W-1:0]           vol_m;
   logic [ENTRY_W-1:0]         entries_m;
   int                         filter_m;
   logic signed [SAMPLE_W-1:0] pos_curve_m [TABLE_SIZE];
   logic signed [SAMPLE_W-1:0] neg_curve_m [TABLE_SIZE];

   shaped_sample_type expected_samples [$];
   int error_count = 0;
   int cycle_count = 0;
   int tx_idle_pct;
   int rx_idle_pct;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Curve lookup with interpolation; returns the signed level, which may be +32768.
   function automatic longint curve_level(logic signed [SAMPLE_W-1:0] s);
      longint mag, span, pos, idx, frac, a, b, level;
      bit     neg;
      mag = (s < 0) ? -longint'(s) : longint'(s);
      mag = mag * longint'(gain_m);
      neg = (s < 0) && (gain_m != 0);
      span = longint'(entries_m);
      if (span < 2) span = 2;
      if (span > TABLE_SIZE) span = TABLE_SIZE;
      if (mag > (longint'(1) << 31)) mag = longint'(1) << 31;
      pos = mag * (span - 1);
      idx = pos >>> 31;
      if (idx >= span - 1) begin
         level = neg ? neg_curve_m[span-1] : pos_curve_m[span-1];
      end else begin
         a = neg ? neg_curve_m[idx] : pos_curve_m[idx];
         b = neg ? neg_curve_m[idx+1] : pos_curve_m[idx+1];
         frac = (pos & 64'h7FFF_FFFF) >> 15;
         level = a + ((frac * (b - a) + 32768) >>> 16);
      end
      return neg ? -level : level;
   endfunction

   // Runs one accepted sample through shaper, lowpass and volume, and queues the result.
   function automatic void record_sample(logic signed [SAMPLE_W-1:0] s, logic be,
                                         logic known, logic signed [SAMPLE_W-1:0] known_out);
      longint wet, coef, volume, delta, y;
      shaped_sample_type item;
      wet = curve_level(s);
      coef = (tone_m > UNITY_Q16) ? UNITY_Q16 : tone_m;
      delta = wet * 128 - filter_m;
      filter_m = filter_m + int'((coef * delta + 32768) >>> 16);
      volume = (vol_m > UNITY_Q16) ? UNITY_Q16 : vol_m;
      y = (longint'(filter_m) * volume + (longint'(1) << 22)) >>> 23;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      item.sample = known ? known_out : y[SAMPLE_W-1:0];
      item.block_end = be;
      expected_samples.push_back(item);
   endfunction

   // Directed table builders.
   function automatic directed_row_type item_row(logic [OP_W-1:0] op, int s, int idx, bit be);
      directed_row_type row;
      row = '0;
      row.op = op;
      row.sample = s[SAMPLE_W-1:0];
      row.index = idx[INDEX_W-1:0];
      row.block_end = be;
      return row;
   endfunction

   function automatic directed_row_type known_row(int s, bit be, int out_value);
      directed_row_type row;
      row = item_row(OP_PROCESS, s, 0, be);
      row.known = 1'b1;
      row.known_out = out_value[SAMPLE_W-1:0];
      return row;
   endfunction

   function automatic directed_row_type reg_row(csr_index_type sel, int data);
      directed_row_type row;
      row = '0;
      row.is_reg = 1'b1;
      row.reg_sel = sel;
      row.reg_data = data[CSR_DATA_W-1:0];
      return row;
   endfunction

   // Random Q1.16 setting for the tone and volume registers, extremes included.
   function automatic logic [CSR_DATA_W-1:0] pick_q16();
      case ($urandom_range(7))
         0: return '0;
         1: return CSR_DATA_W'(UNITY_Q16);
         2: return CSR_DATA_W'($urandom);
         3: return CSR_DATA_W'($urandom_range(1, 4096));
         default: return CSR_DATA_W'($urandom_range(65536));
      endcase
   endfunction

   // Stop sending and let the block finish everything in flight.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write, only issued once the block is idle.
   task automatic write_register(csr_index_type sel, logic [CSR_DATA_W-1:0] data);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (sel)
         CSR_DRIVE_GAIN: gain_m = data[GAIN_W-1:0];
         CSR_TONE_COEF:  tone_m = data[COEF_W-1:0];
         CSR_OUTPUT_VOL: vol_m = data[VOL_W-1:0];
         CSR_ENTRIES:    entries_m = data[ENTRY_W-1:0];
         default: ;
      endcase
   endtask

   // Present one request, wait for the handshake, then update the predictor.
   task automatic send_request(logic [OP_W-1:0] op, logic signed [SAMPLE_W-1:0] s,
                               logic [INDEX_W-1:0] idx, logic be, logic known,
                               logic signed [SAMPLE_W-1:0] known_out);
      // Each cycle before the request the sender idles with the current odds.
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.sample_in <= s;
      req_ch.table_index <= idx;
      req_ch.block_end <= be;
      do @(posedge clock); while (!req_ch.ready);
      if (op == OP_PROCESS) record_sample(s, be, known, known_out);
      else if (op == OP_WR_POS) pos_curve_m[idx] = s;
      else if (op == OP_WR_NEG) neg_curve_m[idx] = s;
   endtask

   // Response side back-pressure.
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Compare each accepted response with the oldest expectation.
   always @(posedge clock) begin : check_response
      shaped_sample_type oldest;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_samples.size() == 0) begin
            if (error_count < MAX_REPORTS)
               $display("%0t unexpected response: expected none, got sample %0d end %0b",
                        $time, rsp_ch.sample_out, rsp_ch.block_end_out);
            error_count++;
         end else begin
            oldest = expected_samples.pop_front();
            if (rsp_ch.sample_out !== oldest.sample) begin
               if (error_count < MAX_REPORTS)
                  $display("%0t sample_out mismatch: expected %0d, got %0d",
                           $time, oldest.sample, rsp_ch.sample_out);
               error_count++;
            end
            if (rsp_ch.block_end_out !== oldest.block_end) begin
               if (error_count < MAX_REPORTS)
                  $display("%0t block_end_out mismatch: expected %0b, got %0b",
                           $time, oldest.block_end, rsp_ch.block_end_out);
               error_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Main stimulus.
   initial begin : stimulus
      directed_row_type           rows [$];
      logic [OP_W-1:0]            op;
      logic signed [SAMPLE_W-1:0] s;
      logic [CSR_DATA_W-1:0]      data;
      int                         pick;
      int                         sent;

      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_DRIVE_GAIN;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.operation <= OP_PROCESS;
      req_ch.sample_in <= '0;
      req_ch.table_index <= '0;
      req_ch.block_end <= 1'b0;
      gain_m = GAIN_RESET;
      tone_m = COEF_RESET;
      vol_m = VOL_RESET;
      entries_m = ENTRIES_RESET;
      filter_m = 0;
      tx_idle_pct = 36;
      rx_idle_pct = 74;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Every entry of both curves is written before any sample reads them.
      for (int i = 0; i < TABLE_SIZE; i++) begin
         send_request(OP_WR_POS, SAMPLE_W'($urandom), INDEX_W'(i), 1'($urandom_range(1)),
                      1'b0, '0);
         send_request(OP_WR_NEG, SAMPLE_W'($urandom), INDEX_W'(i), 1'($urandom_range(1)),
                      1'b0, '0);
      end

      // Corner cases; known results only where the curve end points make them obvious.
      rows = {
         item_row(OP_WR_POS, 1000, 0, 1'b0),
         item_row(OP_WR_POS, 32767, 1022, 1'b0),
         item_row(OP_WR_POS, 32767, TABLE_SIZE - 1, 1'b1),
         item_row(OP_WR_NEG, -32768, TABLE_SIZE - 1, 1'b0),
         known_row(0, 1'b1, 1000),
         known_row(32767, 1'b0, 32767),
         known_row(-32768, 1'b1, 32767),
         item_row(OP_UNKNOWN, 12345, 77, 1'b1),
         item_row(OP_PROCESS, -1, 0, 1'b0),
         item_row(OP_PROCESS, 16384, 0, 1'b1),
         reg_row(CSR_DRIVE_GAIN, 0),
         known_row(-32768, 1'b0, 1000),
         known_row(32767, 1'b1, 1000),
         reg_row(CSR_DRIVE_GAIN, 23'h7F_FFFF),
         item_row(OP_PROCESS, 1, 0, 1'b0),
         known_row(-300, 1'b0, 32767),
         known_row(300, 1'b1, 32767),
         reg_row(CSR_ENTRIES, 0),
         item_row(OP_PROCESS, 100, 0, 1'b0),
         item_row(OP_PROCESS, -5000, 0, 1'b1),
         reg_row(CSR_ENTRIES, 2047),
         known_row(32767, 1'b1, 32767),
         reg_row(CSR_TONE_COEF, 0),
         known_row(0, 1'b0, 32767),
         reg_row(CSR_TONE_COEF, 131071),
         known_row(0, 1'b1, 1000),
         reg_row(CSR_OUTPUT_VOL, 0),
         known_row(32767, 1'b0, 0),
         reg_row(CSR_OUTPUT_VOL, 131071),
         known_row(0, 1'b1, 1000),
         reg_row(CSR_TONE_COEF, 32768),
         item_row(OP_PROCESS, 32767, 0, 1'b0),
         item_row(OP_PROCESS, -32768, 0, 1'b1),
         reg_row(CSR_DRIVE_GAIN, 6553600),
         item_row(OP_PROCESS, 3000, 0, 1'b0),
         item_row(OP_PROCESS, -3000, 0, 1'b1)
      };
      foreach (rows[i]) begin
         if (rows[i].is_reg)
            write_register(rows[i].reg_sel, rows[i].reg_data);
         else
            send_request(rows[i].op, rows[i].sample, rows[i].index, rows[i].block_end,
                         rows[i].known, rows[i].known_out);
      end

      // Random traffic, a fresh register setting per phase.
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == PHASES / 3) begin
            tx_idle_pct = 74;
            rx_idle_pct = 36;
         end else if (phase == 2 * PHASES / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end

         case ($urandom_range(5))
            0: data = '0;
            1: data = GAIN_RESET;
            2: data = CSR_DATA_W'(6553600);
            3: data = '1;
            4: data = CSR_DATA_W'($urandom_range(6553600));
            default: data = CSR_DATA_W'($urandom_range(200000));
         endcase
         write_register(CSR_DRIVE_GAIN, data);
         write_register(CSR_TONE_COEF, pick_q16());
         write_register(CSR_OUTPUT_VOL, pick_q16());
         case ($urandom_range(4))
            0: data = CSR_DATA_W'($urandom_range(3));
            1: data = CSR_DATA_W'(TABLE_SIZE);
            2: data = CSR_DATA_W'($urandom_range(2047));
            default: data = CSR_DATA_W'($urandom_range(2, 16));
         endcase
         write_register(CSR_ENTRIES, data);

         sent = 0;
         while (sent < RANDOM_ITEMS / PHASES) begin
            pick = $urandom_range(99);
            if (pick < 70) op = OP_PROCESS;
            else if (pick < 82) op = OP_WR_POS;
            else if (pick < 94) op = OP_WR_NEG;
            else op = OP_UNKNOWN;
            case ($urandom_range(7))
               0: begin
                  case ($urandom_range(4))
                     0: s = SAMPLE_W'(-32768);
                     1: s = SAMPLE_W'(32767);
                     2: s = '0;
                     3: s = '1;
                     default: s = SAMPLE_W'(1);
                  endcase
               end
               1: s = SAMPLE_W'(int'($urandom_range(512)) - 256);
               default: s = SAMPLE_W'($urandom);
            endcase
            send_request(op, s, INDEX_W'($urandom_range(TABLE_SIZE - 1)),
                         1'($urandom_range(1)), 1'b0, '0);
            if (op != OP_UNKNOWN) sent++;
         end
      end

      wait_idle();
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> filelist.f
sv/lwtf_pkg.sv
sv/lwtf_if.sv
sv/lwtf_front.sv
sv/lwtf_back.sv
sv/lut_waveshaper_with_tone_filter_core.sv
sim/tb_lut_waveshaper_with_tone_filter_core.sv
